FILE: hw/rtl/bbnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbnt_pkg;

  localparam int COORD_W    = 16;
  localparam int MAX_DIMS   = 4;
  localparam int SUM_W      = 36;
  localparam int THRESH_W   = 36;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_WIDEN = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  // register index, taken from paddr[3] (registers sit on 8-byte boundaries)
  localparam logic REG_NEAR_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
  } in_item_t;

  typedef struct packed {
    logic             near;
    logic [SUM_W-1:0] sq_distance;
    logic             box_empty;
  } out_item_t;

  typedef struct packed {
    logic load;     // set bounds to the point
    logic widen;    // stretch bounds to cover the point
    logic s1_take;  // difference register advances
    logic s2_take;  // square register advances
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bounding_box_near_test.sv
// Query pipeline: the difference register loads at the accepting edge, then square,
//   sum, compare/output register.
// Throughput: one item per cycle when the output does not stall; box update is a compare/select
//   per dimension lane, so a query sees a start or widen from the previous cycle.
// Start and widen items produce no result; stall backs up through the 4 stages.
// Synchronous reset clears the box, its valid flag, the threshold and all stage valids.
`timescale 1ns / 1ps
`default_nettype none

module bounding_box_near_test
  import bbnt_pkg::*;
#(
  parameter int DIMS       = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SQ_W = 2 * COORD_BITS;

  logic [THRESH_W-1:0] thresh;
  logic                box_valid;
  logic                s1_valid;
  logic                s1_empty;
  logic                s2_valid;
  logic                s2_empty;
  logic                take1;
  logic                take2;
  logic                s3_take;
  logic                accept;
  logic                is_query;
  logic                do_load;
  logic                do_widen;
  logic                reg_sel;
  lane_ctl_t           lane_ctl;
  logic [COORD_W-1:0]  coord_all [MAX_DIMS];
  logic [SQ_W-1:0]     lane_sq [DIMS];

  // config port
  assign pready  = 1'b1;
  assign reg_sel = paddr[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_NEAR_THRESHOLD) begin
      thresh <= pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_NEAR_THRESHOLD) begin
      prdata = {{(APB_DATA_W-THRESH_W){1'b0}}, thresh};
    end
  end

  // stage handshake
  assign take2    = !s2_valid || s3_take;
  assign take1    = !s1_valid || take2;
  assign in_stall = !take1;
  assign accept   = in_valid && take1;

  assign is_query = in_data.func == FUNC_QUERY;
  assign do_load  = accept && (in_data.func == FUNC_START ||
                               (in_data.func == FUNC_WIDEN && !box_valid));
  assign do_widen = accept && in_data.func == FUNC_WIDEN && box_valid;

  assign lane_ctl.load    = do_load;
  assign lane_ctl.widen   = do_widen;
  assign lane_ctl.s1_take = take1;
  assign lane_ctl.s2_take = take2;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (do_load) begin
        box_valid <= 1'b1;
      end
      if (take1) begin
        s1_valid <= accept && is_query;
      end
      if (take2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      s1_empty <= !box_valid;
    end
    if (take2) begin
      s2_empty <= s1_empty;
    end
  end

  assign coord_all[0] = in_data.coord_0;
  assign coord_all[1] = in_data.coord_1;
  assign coord_all[2] = in_data.coord_2;
  assign coord_all[3] = in_data.coord_3;

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    bbnt_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .coord(coord_all[d][COORD_BITS-1:0]),
      .sq   (lane_sq[d])
    );
  end

  bbnt_merge #(
    .DIMS(DIMS),
    .SQ_W(SQ_W)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_empty (s2_empty),
    .sq       (lane_sq),
    .thresh   (thresh),
    .s3_take  (s3_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
      in_stall |-> s1_valid && s2_valid)
    else $error("input stalled with a free stage");

  a_start_sets_valid: assert property (@(posedge clk) disable iff (rst)
      accept && in_data.func == FUNC_START |=> box_valid)
    else $error("box not valid after start item");

endmodule

`default_nettype wire

FILE: hw/rtl/bbnt_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module bbnt_lane
  import bbnt_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lane_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] coord,
  output logic [2*COORD_BITS-1:0]      sq
);

  logic signed [COORD_BITS-1:0] low;
  logic signed [COORD_BITS-1:0] high;
  logic [COORD_BITS-1:0]        diff;
  logic [COORD_BITS-1:0]        diff_next;
  logic signed [COORD_BITS:0]   ext_c;
  logic signed [COORD_BITS:0]   ext_l;
  logic signed [COORD_BITS:0]   ext_h;
  logic signed [COORD_BITS:0]   diff_wide;
  logic                         below;
  logic                         above;

  assign below = coord < low;
  assign above = coord > high;
  assign ext_c = {coord[COORD_BITS-1], coord};
  assign ext_l = {low[COORD_BITS-1], low};
  assign ext_h = {high[COORD_BITS-1], high};

  // distance to the nearer face; magnitude always fits COORD_BITS unsigned
  always_comb begin
    if (below) begin
      diff_wide = ext_l - ext_c;
    end else if (above) begin
      diff_wide = ext_c - ext_h;
    end else begin
      diff_wide = '0;
    end
    diff_next = diff_wide[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      high <= '0;
    end else if (ctl.load) begin
      low  <= coord;
      high <= coord;
    end else if (ctl.widen) begin
      if (below) begin
        low <= coord;
      end
      if (above) begin
        high <= coord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_take) begin
      diff <= diff_next;
    end
    if (ctl.s2_take) begin
      sq <= {{COORD_BITS{1'b0}}, diff} * {{COORD_BITS{1'b0}}, diff};
    end
  end

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst) low <= high)
    else $error("lane low bound above high bound");

endmodule

`default_nettype wire

FILE: hw/rtl/bbnt_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module bbnt_merge
  import bbnt_pkg::*;
#(
  parameter int DIMS = 4,
  parameter int SQ_W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s2_valid,
  input  logic                s2_empty,
  input  logic [SQ_W-1:0]     sq [DIMS],
  input  logic [THRESH_W-1:0] thresh,
  output logic                s3_take,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  logic             s3_valid;
  logic             s3_empty;
  logic [SUM_W-1:0] s3_sum;
  logic [SUM_W-1:0] sum_next;
  logic             out_take;

  assign out_take = !out_valid || !out_stall;
  assign s3_take  = !s3_valid || out_take;

  always_comb begin
    sum_next = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum_next = sum_next + {{(SUM_W-SQ_W){1'b0}}, sq[d]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_take) begin
        s3_valid <= s2_valid;
      end
      if (out_take) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_empty <= s2_empty;
      s3_sum   <= s2_empty ? '0 : sum_next;
    end
    if (out_take) begin
      out_data.near        <= !s3_empty && (s3_sum <= thresh);
      out_data.sq_distance <= s3_sum;
      out_data.box_empty   <= s3_empty;
    end
  end

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_data.box_empty |-> !out_data.near && out_data.sq_distance == '0)
    else $error("empty-box result reports a distance or near");

endmodule

`default_nettype wire
